>>> src/bfei_pkg.sv
// Shared types and constants for the bit field extract/insert block.
// Used by bfei_ctrl, bfei_dp and bit_field_extract_insert.
`default_nettype none

package bfei_pkg;

    // Opcodes
    localparam logic [2:0] OP_LOAD_BYTE = 3'd0;
    localparam logic [2:0] OP_READ_BYTE = 3'd1;
    localparam logic [2:0] OP_PEEK      = 3'd2;
    localparam logic [2:0] OP_POKE      = 3'd3;
    localparam logic [2:0] OP_PEEK_NEXT = 3'd4;
    localparam logic [2:0] OP_POKE_NEXT = 3'd5;
    localparam logic [2:0] OP_SET_WALK  = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_BIG   = 2'd2;

    localparam logic [6:0]  FIELD_MAX_LEN   = 7'd64;
    localparam logic [15:0] WALK_MAX        = 16'hFFFF;
    localparam logic [7:0]  BUF_BYTES_RESET = 8'd128;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;     // capture the input request
        logic setup;     // check the request, prime counters
        logic run;       // stream bytes through the memory
        logic clear;     // zero one buffer entry
        logic load_out;  // load the result register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic need_run;
        logic run_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> src/bfei_ctrl.sv
// Controller state machine for the bit field extract/insert block.
// Depends on bfei_pkg for the command and status structs.
`default_nettype none

module bfei_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire bfei_pkg::t_dp_stat i_stat,
    output bfei_pkg::t_dp_cmd      o_cmd,
    output logic                   o_idle
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_RUN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_stat.need_run ? S_RUN : S_DONE;
            end
            S_RUN: begin
                o_cmd.run = 1'b1;
                if (i_stat.run_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

`default_nettype wire

>>> src/bfei_dp.sv
// Datapath for the bit field extract/insert block: byte buffer memory,
// walker, range checks, field alignment and result register. Uses bfei_pkg.
`default_nettype none

module bfei_dp #(
    parameter int BUFFER_DEPTH = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bfei_pkg::t_dp_cmd i_cmd,
    output bfei_pkg::t_dp_stat     o_stat,
    input  wire logic              i_cfg_we,
    input  wire logic [7:0]        i_cfg_wdata,
    input  wire logic [2:0]        i_opcode,
    input  wire logic [9:0]        i_bit_position,
    input  wire logic [6:0]        i_field_length,
    input  wire logic [63:0]       i_write_value,
    input  wire logic [6:0]        i_byte_address,
    input  wire logic [7:0]        i_byte_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [63:0]            o_field_value,
    output logic [1:0]             o_status,
    output logic [15:0]            o_walker_position,
    output logic [7:0]             o_byte_out
);

    localparam int         AW      = $clog2(BUFFER_DEPTH);
    localparam logic [13:0] DEPTH14 = 14'(BUFFER_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);

    logic [7:0] r_mem [BUFFER_DEPTH];
    logic [7:0] r_rdata;

    // Latched request
    logic [2:0]  r_op;
    logic [9:0]  r_pos;
    logic [6:0]  r_len;
    logic [63:0] r_wv;
    logic [6:0]  r_baddr;
    logic [7:0]  r_bdata;

    logic [7:0]    r_buf_bytes;
    logic [15:0]   r_walk;
    logic [AW-1:0] r_clr_addr;

    logic [1:0]    r_status;
    logic [3:0]    r_rd_left;
    logic [AW-1:0] r_addr;
    logic          r_down;
    logic          r_pend;
    logic [AW-1:0] r_pend_addr;
    logic [71:0]   r_acc;
    logic [71:0]   r_wsh;
    logic [71:0]   r_msk;
    logic [2:0]    r_drop;

    logic          r_out_valid;
    logic [63:0]   r_field_value;
    logic [1:0]    r_out_status;
    logic [15:0]   r_out_walk;
    logic [7:0]    r_byte_out;

    // Setup decode
    logic          is_next;
    logic          is_peek;
    logic          is_poke;
    logic [15:0]   start16;
    logic [16:0]   last17;
    logic [13:0]   eff14;
    logic          len_ok;
    logic          fld_ok;
    logic          addr_ok;
    logic [63:0]   lenmask;
    logic          too_big;
    logic [2:0]    drop;
    logic [3:0]    nbytes;
    logic [16:0]   walk_sum;
    logic [15:0]   walk_adv;
    logic [1:0]    n_status;
    logic          n_run;
    logic [3:0]    n_rd_left;
    logic [AW-1:0] n_addr;

    // Memory port control
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [63:0]   peek_val;
    logic          out_take;

    always_comb begin
        is_next  = (r_op == bfei_pkg::OP_PEEK_NEXT) || (r_op == bfei_pkg::OP_POKE_NEXT);
        is_peek  = (r_op == bfei_pkg::OP_PEEK) || (r_op == bfei_pkg::OP_PEEK_NEXT);
        is_poke  = (r_op == bfei_pkg::OP_POKE) || (r_op == bfei_pkg::OP_POKE_NEXT);
        start16  = is_next ? r_walk : 16'(r_pos);
        last17   = 17'(start16) + 17'(r_len) - 17'd1;
        eff14    = (14'(r_buf_bytes) < DEPTH14) ? 14'(r_buf_bytes) : DEPTH14;
        len_ok   = (r_len != 7'd0) && (r_len <= bfei_pkg::FIELD_MAX_LEN);
        fld_ok   = len_ok && (last17[16:3] < eff14);
        addr_ok  = 14'(r_baddr) < DEPTH14;
        lenmask  = (r_len >= bfei_pkg::FIELD_MAX_LEN) ? {64{1'b1}}
                 : ((64'd1 << r_len[5:0]) - 64'd1);
        too_big  = (r_wv & ~lenmask) != 64'd0;
        drop     = ~last17[2:0];
        nbytes   = last17[6:3] - start16[6:3] + 4'd1;
        walk_sum = 17'(r_walk) + 17'(r_len);
        walk_adv = walk_sum[16] ? bfei_pkg::WALK_MAX : walk_sum[15:0];

        n_status  = bfei_pkg::ST_OK;
        n_run     = 1'b0;
        n_rd_left = 4'd0;
        n_addr    = AW'(r_baddr);
        case (r_op)
            bfei_pkg::OP_LOAD_BYTE: begin
                n_status = addr_ok ? bfei_pkg::ST_OK : bfei_pkg::ST_RANGE;
            end
            bfei_pkg::OP_READ_BYTE: begin
                n_status  = addr_ok ? bfei_pkg::ST_OK : bfei_pkg::ST_RANGE;
                n_run     = addr_ok;
                n_rd_left = 4'd1;
            end
            bfei_pkg::OP_PEEK, bfei_pkg::OP_PEEK_NEXT: begin
                n_status  = fld_ok ? bfei_pkg::ST_OK : bfei_pkg::ST_RANGE;
                n_run     = fld_ok;
                n_rd_left = nbytes;
                n_addr    = AW'(start16[15:3]);
            end
            bfei_pkg::OP_POKE, bfei_pkg::OP_POKE_NEXT: begin
                if (!fld_ok) begin
                    n_status = bfei_pkg::ST_RANGE;
                end else if (too_big) begin
                    n_status = bfei_pkg::ST_BIG;
                end else begin
                    n_status = bfei_pkg::ST_OK;
                    n_run    = 1'b1;
                end
                n_rd_left = nbytes;
                n_addr    = AW'(last17[16:3]);
            end
            default: begin
                n_status = bfei_pkg::ST_OK;
            end
        endcase
    end

    assign o_stat.clr_last = (r_clr_addr == LAST_ADDR);
    assign o_stat.need_run = n_run;
    assign o_stat.run_done = (r_rd_left == 4'd0) && !r_pend;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // Request latch, config and walker
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_opcode;
            r_pos   <= i_bit_position;
            r_len   <= i_field_length;
            r_wv    <= i_write_value;
            r_baddr <= i_byte_address;
            r_bdata <= i_byte_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_bytes <= bfei_pkg::BUF_BYTES_RESET;
            r_walk      <= 16'd0;
            r_clr_addr  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_buf_bytes <= i_cfg_wdata;
            end
            if (i_cmd.setup) begin
                if (is_next) begin
                    r_walk <= walk_adv;
                end else if (r_op == bfei_pkg::OP_SET_WALK) begin
                    r_walk <= 16'(r_pos);
                end
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // Byte streaming: one read issued per cycle, the byte read last cycle
    // is merged (poke) or shifted into the accumulator (peek, read byte).
    always_comb begin
        rd_en   = i_cmd.run && (r_rd_left != 4'd0);
        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_data = 8'd0;
        if (i_cmd.clear) begin
            wr_en = 1'b1;
        end else if (i_cmd.setup && (r_op == bfei_pkg::OP_LOAD_BYTE) && addr_ok) begin
            wr_en   = 1'b1;
            wr_addr = AW'(r_baddr);
            wr_data = r_bdata;
        end else if (i_cmd.run && r_pend && is_poke) begin
            wr_en   = 1'b1;
            wr_addr = r_pend_addr;
            wr_data = (r_rdata & ~r_msk[7:0]) | (r_wsh[7:0] & r_msk[7:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_left <= 4'd0;
            r_pend    <= 1'b0;
        end else if (i_cmd.setup) begin
            r_rd_left <= n_run ? n_rd_left : 4'd0;
            r_pend    <= 1'b0;
        end else if (i_cmd.run) begin
            r_pend <= rd_en;
            if (rd_en) begin
                r_rd_left <= r_rd_left - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_status <= n_status;
            r_addr   <= n_addr;
            r_down   <= is_poke;
            r_acc    <= 72'd0;
            r_wsh    <= 72'(r_wv) << drop;
            r_msk    <= 72'(lenmask) << drop;
            r_drop   <= drop;
        end else if (i_cmd.run) begin
            if (rd_en) begin
                r_addr      <= r_down ? (r_addr - AW'(1)) : (r_addr + AW'(1));
                r_pend_addr <= r_addr;
            end
            if (r_pend) begin
                if (r_down) begin
                    r_wsh <= r_wsh >> 8;
                    r_msk <= r_msk >> 8;
                end else begin
                    r_acc <= {r_acc[63:0], r_rdata};
                end
            end
        end
    end

    // Result register
    always_comb begin
        peek_val = 64'(r_acc >> r_drop) & lenmask;
        out_take = r_out_valid && !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_field_value <= (is_peek && (r_status == bfei_pkg::ST_OK)) ? peek_val : 64'd0;
            r_byte_out    <= ((r_op == bfei_pkg::OP_READ_BYTE) &&
                              (r_status == bfei_pkg::ST_OK)) ? r_acc[7:0] : 8'd0;
            r_out_status  <= r_status;
            r_out_walk    <= r_walk;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_field_value     = r_field_value;
    assign o_status          = r_out_status;
    assign o_walker_position = r_out_walk;
    assign o_byte_out        = r_byte_out;

endmodule

`default_nettype wire

>>> src/bit_field_extract_insert.sv
// MSB-first bit field extract/insert over a byte buffer; top level joining
// bfei_ctrl and bfei_dp, uses bfei_pkg. One request at a time: a peek, poke
// or byte read streams the n buffer bytes it touches (up to 9 for a 64-bit
// field), reading each one and, for a poke, writing it back merged. Byte
// load, set walker and rejected fields skip the streaming. Reset (synchronous)
// zeros the walker, sets buffer_bytes to 128, then clears every buffer entry.
`default_nettype none

module bit_field_extract_insert #(
    parameter int BUFFER_DEPTH = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: buffer_bytes
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    // Request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [9:0]  i_bit_position,
    input  wire logic [6:0]  i_field_length,
    input  wire logic [63:0] i_write_value,
    input  wire logic [6:0]  i_byte_address,
    input  wire logic [7:0]  i_byte_data,
    // Result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_field_value,
    output logic [1:0]       o_status,
    output logic [15:0]      o_walker_position,
    output logic [7:0]       o_byte_out
);

    bfei_pkg::t_dp_cmd  cmd;
    bfei_pkg::t_dp_stat stat;
    logic               ctrl_idle;

    // Take a request only in idle; the result register lets the next request
    // in while the previous result still waits downstream. Hold stall in reset.
    assign o_in_stall = !ctrl_idle || !i_rst_n;

    // Sequence clear sweep, setup, byte streaming and result load.
    bfei_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idle     (ctrl_idle)
    );

    // Buffer memory, walker, range checks and result register.
    bfei_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_opcode          (i_opcode),
        .i_bit_position    (i_bit_position),
        .i_field_length    (i_field_length),
        .i_write_value     (i_write_value),
        .i_byte_address    (i_byte_address),
        .i_byte_data       (i_byte_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_field_value     (o_field_value),
        .o_status          (o_status),
        .o_walker_position (o_walker_position),
        .o_byte_out        (o_byte_out)
    );

endmodule

`default_nettype wire
